[sv/wps_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the weight and position smoother.
// Used by wps_lane, weight_position_smoother and wps_checker.

package wps_pkg;

  localparam int TS_W       = 32;   // timestamp width in bits
  localparam int WIN_W      = 8;    // width of the averaging window register
  localparam int INT_W      = 16;   // width of the commit interval register
  localparam int CFG_AW     = 1;    // configuration register index width
  localparam int CFG_DW     = 16;   // configuration write data width
  localparam int ONE_Q      = 256;  // 1.0 in Q16.8
  localparam int WIN_RESET  = 30;
  localparam int INT_RESET  = 300;

  typedef logic [CFG_AW-1:0] cfg_addr_t;

  localparam cfg_addr_t CFG_WINDOW   = 1'b0;
  localparam cfg_addr_t CFG_INTERVAL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_COMMIT
  } wps_state_e;

  // Step strobes from the sequencer to the averaging lanes.
  typedef struct packed {
    logic load;      // capture a new sample and start the multiply
    logic mul;       // one shift-add step of the multiply
    logic div_load;  // form the dividend and load the divider
    logic div_step;  // one restoring division step
    logic commit;    // write the new average into the state
  } wps_ctl_t;

endpackage

[sv/wps_div.sv]
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per step, MSB first.
// Standalone; the caller holds the divisor stable while it steps.

module wps_div #(
  parameter int RW = 8,   // remainder and divisor width
  parameter int QW = 24   // quotient width
) (
  input  logic          clk_i,
  input  logic          load_i,
  input  logic          step_i,
  input  logic [RW-1:0] rem_init_i,
  input  logic [QW-1:0] quo_init_i,
  input  logic [RW-1:0] divisor_i,
  output logic [QW-1:0] quotient_o
);

  logic [RW-1:0] rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          take;

  // The dividend bits shift out of the top of quo_q while the quotient
  // bits shift in at the bottom.
  always_comb begin
    trial = {rem_q, quo_q[QW-1]};
    diff  = trial - {1'b0, divisor_i};
    take  = trial >= {1'b0, divisor_i};
    rem_d = rem_q;
    quo_d = quo_q;
    if (load_i) begin
      rem_d = rem_init_i;
      quo_d = quo_init_i;
    end else if (step_i) begin
      rem_d = take ? diff[RW-1:0] : trial[RW-1:0];
      quo_d = {quo_q[QW-2:0], take};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;

endmodule

[sv/wps_lane.sv]
`timescale 1ns / 1ps
// One recursive average lane: avg = (avg*(N-1) + new) / N, truncated.
// Bit-serial multiply, then wps_div; uses wps_pkg.

module wps_lane #(
  parameter int SW = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wps_pkg::wps_ctl_t   ctl_i,
  input  logic                clamp_i,
  input  logic [wps_pkg::WIN_W-1:0] window_i,
  input  logic signed [SW-1:0] sample_i,
  output logic signed [SW-1:0] avg_next_o,
  output logic signed [SW-1:0] avg_o
);

  localparam int AW = SW + wps_pkg::WIN_W;      // product width
  localparam int DW = SW + wps_pkg::WIN_W + 1;  // dividend width with sign
  localparam logic signed [SW-1:0] ONE = SW'(wps_pkg::ONE_Q);

  logic signed [SW-1:0]            avg_q;
  logic signed [SW-1:0]            sample_q;
  logic [wps_pkg::WIN_W-1:0]       mplr_q;
  logic signed [AW-1:0]            acc_q;
  logic                            neg_q;
  logic signed [DW-1:0]            total;
  logic [DW-1:0]                   mag;
  logic [SW-1:0]                   quo;
  logic signed [SW-1:0]            quo_s;
  logic signed [SW-1:0]            res;

  always_comb begin
    total = DW'(acc_q) + DW'(sample_q);
    mag   = total[DW-1] ? DW'(-total) : DW'(total);
  end

  // The top bits of the magnitude are always below N, so they seed the
  // remainder and only SW quotient bits are needed.
  wps_div #(
    .RW (wps_pkg::WIN_W),
    .QW (SW)
  ) u_div (
    .clk_i      (clk_i),
    .load_i     (ctl_i.div_load),
    .step_i     (ctl_i.div_step),
    .rem_init_i (mag[SW+wps_pkg::WIN_W-1:SW]),
    .quo_init_i (mag[SW-1:0]),
    .divisor_i  (window_i),
    .quotient_o (quo)
  );

  always_comb begin
    quo_s = neg_q ? -$signed(quo) : $signed(quo);
    if (window_i == '0) begin
      res = sample_q;
    end else begin
      res = quo_s;
    end
    if (sample_q > -ONE && sample_q < ONE) begin
      res = '0;
    end
    if (clamp_i && res < ONE) begin
      res = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      sample_q <= sample_i;
      mplr_q   <= window_i - wps_pkg::WIN_W'(1);
      acc_q    <= '0;
    end else if (ctl_i.mul) begin
      acc_q  <= (acc_q <<< 1) + (mplr_q[wps_pkg::WIN_W-1] ? AW'(avg_q) : AW'(0));
      mplr_q <= mplr_q << 1;
    end
    if (ctl_i.div_load) begin
      neg_q <= total[DW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else if (ctl_i.commit) begin
      avg_q <= res;
    end
  end

  assign avg_next_o = res;
  assign avg_o      = avg_q;

endmodule

[sv/weight_position_smoother.sv]
`timescale 1ns / 1ps
// Top level of the weight and position smoother.
// Uses wps_pkg, wps_lane and wps_div.
//
// Usage: each beat on the s_axis side carries a weight sample, an x and a y
// position (signed Q16.8) and a millisecond timestamp. Each beat produces
// exactly one beat on the m_axis side with the smoothed weight, the
// interval-averaged weight indication and the smoothed x and y positions.
// The configuration channel writes the averaging window (index 0) and the
// commit interval in ms (index 1); write it only while no beat is in flight.
// Processing: once a beat is accepted, the lanes run the bit-serial multiply
// by N-1, form the dividend, run the bit-serial divider and commit the result.
// The block then returns to idle, where the next beat is accepted. The
// interval mean divider runs alongside the lanes.
// One beat is processed at a time; s_axis_tready is high only when idle.
// Reset clears all averages, the interval sum and count and the last commit
// time, and loads window 30 and interval 300 ms. If the receiver stalls, the
// result is held and the next beat is accepted and processed, but it is not
// committed until the held result has been taken.

module weight_position_smoother #(
  parameter int SAMPLE_WIDTH       = 24,
  parameter int MAX_INTERVAL_COUNT = 1024,
  localparam int IN_W  = ((3 * SAMPLE_WIDTH + wps_pkg::TS_W + 7) / 8) * 8,
  localparam int OUT_W = ((4 * SAMPLE_WIDTH - 2 + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // weight_sample, x_position, y_position, timestamp_ms
  input  logic [IN_W-1:0]             s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // smoothed_weight, weight_indication, smoothed_x, smoothed_y
  output logic [OUT_W-1:0]            m_axis_tdata,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wps_pkg::cfg_addr_t          cfg_addr_i,
  input  logic [wps_pkg::CFG_DW-1:0]  cfg_data_i
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CW    = $clog2(MAX_INTERVAL_COUNT + 1);
  localparam int SUMW  = SW - 1 + CW;
  localparam int CNT_W = $clog2(SW);
  localparam int TS_W  = wps_pkg::TS_W;

  wps_pkg::wps_state_e       state_q, state_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  wps_pkg::wps_ctl_t         ctl;
  logic                      out_free;
  logic                      m_valid_q, m_valid_d;

  logic [wps_pkg::WIN_W-1:0] window_q;
  logic [wps_pkg::INT_W-1:0] interval_q;
  logic [TS_W-1:0]           ts_q;
  logic [TS_W-1:0]           last_q, last_d;
  logic [SUMW-1:0]           sum_q, sum_d;
  logic [CW-1:0]             count_q, count_d;
  logic [SW-2:0]             ind_q, ind_d;

  logic signed [SW-1:0]      w_next, w_avg, x_avg, y_avg;
  logic signed [SW-1:0]      x_next, y_next;
  logic [SW-1:0]             mean_quo;
  logic [TS_W-1:0]           elapsed;
  logic                      collect;
  logic [SW-2:0]             w_u;

  assign out_free = !m_valid_q || m_axis_tready;

  // Sequencer
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    ctl           = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      wps_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          ctl.load = 1'b1;
          cnt_d    = '0;
          state_d  = wps_pkg::ST_MUL;
        end
      end
      wps_pkg::ST_MUL: begin
        ctl.mul = 1'b1;
        if (cnt_q == CNT_W'(wps_pkg::WIN_W - 1)) begin
          cnt_d   = '0;
          state_d = wps_pkg::ST_DLOAD;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      wps_pkg::ST_DLOAD: begin
        ctl.div_load = 1'b1;
        state_d      = wps_pkg::ST_DIV;
      end
      wps_pkg::ST_DIV: begin
        ctl.div_step = 1'b1;
        if (cnt_q == CNT_W'(SW - 1)) begin
          cnt_d   = '0;
          state_d = wps_pkg::ST_COMMIT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      wps_pkg::ST_COMMIT: begin
        if (out_free) begin
          ctl.commit = 1'b1;
          state_d    = wps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wps_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  wps_lane #(.SW(SW)) u_lane_w (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .clamp_i    (1'b1),
    .window_i   (window_q),
    .sample_i   ($signed(s_axis_tdata[SW-1:0])),
    .avg_next_o (w_next),
    .avg_o      (w_avg)
  );

  wps_lane #(.SW(SW)) u_lane_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .clamp_i    (1'b0),
    .window_i   (window_q),
    .sample_i   ($signed(s_axis_tdata[2*SW-1:SW])),
    .avg_next_o (x_next),
    .avg_o      (x_avg)
  );

  wps_lane #(.SW(SW)) u_lane_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .clamp_i    (1'b0),
    .window_i   (window_q),
    .sample_i   ($signed(s_axis_tdata[3*SW-1:2*SW])),
    .avg_next_o (y_next),
    .avg_o      (y_avg)
  );

  // Interval mean of the previous state; the sum over the count is below
  // 2^(SW-1), so its top bits already sit below the count.
  wps_div #(
    .RW (CW),
    .QW (SW)
  ) u_mean_div (
    .clk_i      (clk_i),
    .load_i     (ctl.div_load),
    .step_i     (ctl.div_step),
    .rem_init_i (CW'(sum_q[SUMW-1:SW])),
    .quo_init_i (sum_q[SW-1:0]),
    .divisor_i  (count_q),
    .quotient_o (mean_quo)
  );

  always_comb begin
    elapsed = ts_q - last_q;
    collect = elapsed < TS_W'(interval_q);
    w_u     = w_next[SW-2:0];
    last_d  = last_q;
    sum_d   = sum_q;
    count_d = count_q;
    ind_d   = ind_q;
    if (ctl.commit) begin
      if (collect) begin
        if (count_q < CW'(MAX_INTERVAL_COUNT)) begin
          sum_d   = sum_q + SUMW'(w_u);
          count_d = count_q + CW'(1);
        end
      end else begin
        last_d  = ts_q;
        ind_d   = (count_q != '0) ? mean_quo[SW-2:0] : w_u;
        sum_d   = '0;
        count_d = '0;
      end
      // A weight below 1.0 has been clamped to zero and blanks the display.
      if (w_next == '0) begin
        ind_d = '0;
      end
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (ctl.commit) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load) begin
      ts_q <= s_axis_tdata[3*SW+TS_W-1:3*SW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= wps_pkg::WIN_W'(wps_pkg::WIN_RESET);
      interval_q <= wps_pkg::INT_W'(wps_pkg::INT_RESET);
      last_q     <= '0;
      sum_q      <= '0;
      count_q    <= '0;
      ind_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      last_q    <= last_d;
      sum_q     <= sum_d;
      count_q   <= count_d;
      ind_q     <= ind_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          wps_pkg::CFG_WINDOW:   window_q   <= cfg_data_i[wps_pkg::WIN_W-1:0];
          wps_pkg::CFG_INTERVAL: interval_q <= cfg_data_i[wps_pkg::INT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  // The lane state registers only change on commit, which waits for the
  // output to be free, so they serve as the output register.
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({y_avg, x_avg, ind_q, w_avg[SW-2:0]});

endmodule

[sv/wps_checker.sv]
`timescale 1ns / 1ps
// Port-level checker of the weight and position smoother and its bind.
// Depends on weight_position_smoother only through its ports.

module wps_port_checker #(
  parameter int SAMPLE_WIDTH = 24,
  localparam int OUT_W = ((4 * SAMPLE_WIDTH - 2 + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  localparam int SW = SAMPLE_WIDTH;

  // An accepted beat keeps the block busy, so the input is not ready right after an accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a beat is still being processed");

  // A new result appears only as the block returns to idle.
  a_result_on_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result raised while the block is still busy");

  // A zero weight average always blanks the indication.
  a_zero_weight_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[SW-2:0] == '0 |-> m_axis_tdata[2*SW-3:SW-1] == '0)
    else $error("indication nonzero while the weight average is zero");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

endmodule

bind weight_position_smoother wps_port_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_wps_checker (.*);

[test/wps_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the weight and position smoother: watches the sample, result
// and configuration channels, predicts every result and compares it.
// Depends on wps_pkg for the register indexes and the configuration widths.

module wps_checker #(
  parameter int MAX_COUNT = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  // weight_sample, x_position, y_position, timestamp_ms
  input  logic [103:0]               in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  // smoothed_weight, weight_indication, smoothed_x, smoothed_y
  input  logic [95:0]                out_data_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  wps_pkg::cfg_addr_t         cfg_addr_i,
  input  logic [wps_pkg::CFG_DW-1:0] cfg_data_i,
  output int                         pending_o,
  output int                         fail_count_o
);

  typedef struct packed {
    logic [22:0] weight;
    logic [22:0] indication;
    logic [23:0] x;
    logic [23:0] y;
  } smooth_beat_t;

  logic [wps_pkg::WIN_W-1:0] window_q;
  logic [wps_pkg::INT_W-1:0] interval_q;
  longint                    avg_w_q;
  longint                    avg_x_q;
  longint                    avg_y_q;
  longint                    sum_q;
  longint                    count_q;
  longint                    indication_q;
  logic [wps_pkg::TS_W-1:0]  last_commit_q;
  smooth_beat_t              expected_q[$];
  int                        fails;

  function automatic longint avg_next(longint avg, longint smp,
                                      logic [wps_pkg::WIN_W-1:0] n);
    longint r;
    if (n == 0) begin
      r = smp;
    end else begin
      r = (avg * (longint'(n) - 1) + smp) / longint'(n);
    end
    // A sample below 1.0 in magnitude drops its average to zero.
    if (smp > -wps_pkg::ONE_Q && smp < wps_pkg::ONE_Q) begin
      r = 0;
    end
    return r;
  endfunction

  function automatic smooth_beat_t smooth_step(logic [103:0] d);
    logic signed [23:0]       w;
    logic signed [23:0]       x;
    logic signed [23:0]       y;
    logic [wps_pkg::TS_W-1:0] ts;
    logic [wps_pkg::TS_W-1:0] elapsed;
    smooth_beat_t             res;
    w  = d[23:0];
    x  = d[47:24];
    y  = d[71:48];
    ts = d[103:72];

    avg_w_q = avg_next(avg_w_q, longint'(w), window_q);
    if (avg_w_q < wps_pkg::ONE_Q) begin
      avg_w_q = 0;
    end

    elapsed = ts - last_commit_q;
    if (elapsed < interval_q) begin
      if (count_q < MAX_COUNT) begin
        sum_q   = sum_q + avg_w_q;
        count_q = count_q + 1;
      end
    end else begin
      last_commit_q = ts;
      indication_q  = (count_q != 0) ? sum_q / count_q : avg_w_q;
      sum_q   = 0;
      count_q = 0;
    end
    if (avg_w_q < wps_pkg::ONE_Q) begin
      indication_q = 0;
    end

    avg_x_q = avg_next(avg_x_q, longint'(x), window_q);
    avg_y_q = avg_next(avg_y_q, longint'(y), window_q);

    res.weight     = avg_w_q[22:0];
    res.indication = indication_q[22:0];
    res.x          = avg_x_q[23:0];
    res.y          = avg_y_q[23:0];
    return res;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    smooth_beat_t got;
    smooth_beat_t want;
    if (!rst_ni) begin
      window_q      = wps_pkg::WIN_W'(wps_pkg::WIN_RESET);
      interval_q    = wps_pkg::INT_W'(wps_pkg::INT_RESET);
      avg_w_q       = 0;
      avg_x_q       = 0;
      avg_y_q       = 0;
      sum_q         = 0;
      count_q       = 0;
      indication_q  = 0;
      last_commit_q = '0;
      fails         = 0;
      expected_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // A result beat always belongs to an older sample, so it is retired
      // before a sample accepted at the same edge is predicted.
      if (out_valid_i && out_ready_i) begin
        got.weight     = out_data_i[22:0];
        got.indication = out_data_i[45:23];
        got.x          = out_data_i[69:46];
        got.y          = out_data_i[93:70];
        if (expected_q.size() == 0) begin
          $error("result beat with no sample waiting for it");
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("smoothed_weight", want.weight, got.weight);
          check_field("weight_indication", want.indication, got.indication);
          check_field("smoothed_x", $signed(want.x), $signed(got.x));
          check_field("smoothed_y", $signed(want.y), $signed(got.y));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_addr_i == wps_pkg::CFG_WINDOW) begin
          window_q = cfg_data_i[wps_pkg::WIN_W-1:0];
        end else begin
          interval_q = cfg_data_i[wps_pkg::INT_W-1:0];
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(smooth_step(in_data_i));
      end
      pending_o    <= expected_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Top of the weight and position smoother testbench: clock, reset, sample and
// configuration stimulus, result-side back pressure and the verdict.
// Depends on wps_pkg, weight_position_smoother and wps_checker.

module tb;

  localparam int IN_W  = 104;
  localparam int OUT_W = 96;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [IN_W-1:0]            s_axis_tdata;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [OUT_W-1:0]           m_axis_tdata;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  wps_pkg::cfg_addr_t         cfg_addr_i;
  logic [wps_pkg::CFG_DW-1:0] cfg_data_i;

  int                         pending;
  int                         fail_count;
  bit                         no_gaps  = 1'b0;
  bit                         hold_req = 1'b0;
  logic [wps_pkg::TS_W-1:0]   now_ms;

  always #1 clk_i = ~clk_i;

  weight_position_smoother u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  wps_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  task automatic send_sample(logic [23:0] w, logic [23:0] x, logic [23:0] y,
                             logic [wps_pkg::TS_W-1:0] ts);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ts, y, x, w};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(wps_pkg::cfg_addr_t addr, logic [wps_pkg::CFG_DW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // The upper byte of a window write is noise that the block must ignore.
  task automatic set_config(logic [wps_pkg::WIN_W-1:0] win,
                            logic [wps_pkg::INT_W-1:0] intv);
    write_reg(wps_pkg::CFG_WINDOW, {8'($urandom()), win});
    write_reg(wps_pkg::CFG_INTERVAL, intv);
  endtask

  task automatic wait_empty();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic drain();
    wait_empty();
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [23:0] pick_sample(int center, int spread);
    case ($urandom_range(0, 15))
      0:       return 24'($urandom());
      1:       return 24'(int'($urandom_range(0, 510)) - 255);
      2:       return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      3:       return 24'((wps_pkg::ONE_Q - 1 + int'($urandom_range(0, 2)))
                          * ($urandom_range(0, 1) ? 1 : -1));
      default: return 24'(center - spread + int'($urandom_range(0, 2 * spread)));
    endcase
  endfunction

  task automatic run_phase(int count, int w_center, int w_spread, int step_max, bit jumps);
    for (int i = 0; i < count; i++) begin
      if (jumps && $urandom_range(0, 19) == 0) begin
        now_ms = $urandom();
      end else begin
        now_ms = now_ms + $urandom_range(0, step_max);
      end
      send_sample(pick_sample(w_center, w_spread), pick_sample(0, 'h3000),
                  pick_sample('h1800, 'h3000), now_ms);
    end
  endtask

  // Result side: a random hold-off before every beat unless no_gaps is set, or one long stall on request.
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        gap = 400;
        hold_req = 1'b0;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 6);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  initial begin
    int win;
    int intv;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_addr_i    <= wps_pkg::CFG_WINDOW;
    cfg_data_i    <= '0;
    now_ms         = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: extremes, the 1.0 threshold and timestamp wrap.
    send_sample(24'h000000, 24'h000000, 24'h000000, 32'd0);
    send_sample(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 32'd10);
    send_sample(24'h800000, 24'h800000, 24'h7FFFFF, 32'd20);
    send_sample(24'h0000FF, 24'hFFFF01, 24'h000100, 32'd30);
    send_sample(24'h000100, 24'hFFFF00, 24'hFFFEFF, 32'd40);
    send_sample(24'h010000, 24'h010000, 24'hFF0000, 32'd299);
    send_sample(24'h010000, 24'h020000, 24'hFE0000, 32'd300);
    send_sample(24'h010000, 24'h030000, 24'hFD0000, 32'd600);
    send_sample(24'hFFFFFF, 24'h030000, 24'hFD0000, 32'd700);
    send_sample(24'h020000, 24'h030000, 24'hFD0000, 32'hFFFF_FFF0);
    send_sample(24'h020000, 24'h030000, 24'hFD0000, 32'hFFFF_FFFF);
    send_sample(24'h020000, 24'h030000, 24'hFD0000, 32'h0000_0005);
    drain();
    // Window of zero passes samples through; interval of zero commits every beat.
    set_config(8'd0, 16'd0);
    send_sample(24'h012345, 24'hFEDCBA, 24'h000080, 32'd1000);
    send_sample(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 32'd1000);
    send_sample(24'h000055, 24'h000100, 24'hFFFF00, 32'd1001);
    send_sample(24'h040000, 24'h00FFFF, 24'hFF0001, 32'd1005);
    drain();
    set_config(8'd255, 16'd65535);
    send_sample(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 32'd2000);
    send_sample(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 32'd2001);
    send_sample(24'h800000, 24'h123456, 24'h654321, 32'd50000);
    send_sample(24'h010000, 24'hABCDEF, 24'h00FF00, 32'd70000);
    drain();
    set_config(8'd1, 16'd1);
    send_sample(24'h030000, 24'h001234, 24'hFFEDCC, 32'd70000);
    send_sample(24'h030100, 24'h001235, 24'hFFEDCD, 32'd70000);
    send_sample(24'h030200, 24'h001236, 24'hFFEDCE, 32'd70001);
    drain();

    // Random part, starting from the reset settings.
    set_config(8'd30, 16'd300);
    run_phase(20, 'h20000, 'h2000, 60, 1'b1);
    // Long result stall while samples keep coming, then a full pause.
    hold_req = 1'b1;
    run_phase(20, 'h20000, 'h2000, 60, 1'b1);
    wait_empty();
    run_phase(15, 'h20000, 'h2000, 60, 1'b1);
    drain();

    set_config(8'd0, 16'd0);
    no_gaps = 1'b1;
    run_phase(20, 'h8000, 'h4000, 3, 1'b1);
    no_gaps = 1'b0;
    drain();

    set_config(8'd255, 16'd65535);
    run_phase(20, 'h30000, 'h8000, 500, 1'b1);
    drain();

    set_config(8'd1, 16'd20);
    run_phase(20, 'h1000, 'h0800, 8, 1'b1);
    drain();

    // One long interval with a fixed clock drives the count into saturation.
    set_config(8'd4, 16'd65535);
    now_ms = $urandom();
    run_phase(1040, 'h20000, 'h1000, 0, 1'b0);
    drain();

    repeat (3) begin
      win  = $urandom_range(0, 255);
      intv = $urandom_range(0, 65535);
      set_config(wps_pkg::WIN_W'(win), wps_pkg::INT_W'(intv));
      run_phase(8, 'h18000, 'h10000, intv / 8 + 1, 1'b1);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASS weight_position_smoother");
    end else begin
      $display("FAIL weight_position_smoother");
    end
    $finish;
  end

  initial begin
    #1_400_000;
    $display("FAIL weight_position_smoother");
    $finish;
  end

endmodule
